// ===== sv/rtnv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtnv_pkg
// Shared types and constants of the RGB to NV21 converter.
// ----------------------------------------------------------------------------
package rtnv_pkg;

   localparam int ADDR_WIDTH      = 25;
   localparam int DIM_WIDTH       = 13;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int FIFO_DEPTH      = 4;

   localparam int DEFAULT_WIDTH   = 640;
   localparam int DEFAULT_HEIGHT  = 480;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_FRAME_HEIGHT = 2'd1;

   typedef struct packed {
      logic                       valid;
      logic [CSR_INDEX_WIDTH-1:0] index;
      logic [DIM_WIDTH-1:0]       data;
   } csr_write_type;

   // one accepted pixel, fully converted, waiting for its byte writes
   typedef struct packed {
      logic [ADDR_WIDTH-1:0] luma_addr;
      logic [ADDR_WIDTH-1:0] chroma_addr;
      logic [7:0]            y_byte;
      logic [7:0]            v_byte;
      logic [7:0]            u_byte;
      logic                  has_chroma;
   } pix_entry_type;

endpackage
`default_nettype wire

// ===== sv/rtnv_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtnv_fifo
// Short queue of converted pixels between the front and the back end.
// ----------------------------------------------------------------------------
module rtnv_fifo
   import rtnv_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          wr_en,
   input  wire pix_entry_type wr_data,
   input  wire logic          rd_en,
   output pix_entry_type      rd_data,
   output logic              full,
   output logic              empty
);

   localparam int PTR_W = $clog2(FIFO_DEPTH);

   pix_entry_type          mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]         count_ff, count_in;
   logic                   do_wr, do_rd;

   assign full    = (count_ff == (PTR_W+1)'(FIFO_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule
`default_nettype wire

// ===== sv/rtnv_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtnv_front
// Accepts pixels, tracks raster position and plane addresses, converts the
// pixel to Y/V/U and hands one entry per pixel to the queue. Holds the
// frame size registers.
// ----------------------------------------------------------------------------
module rtnv_front
   import rtnv_pkg::*;
#(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
)
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire csr_write_type csr,
   input  wire logic          req_push,
   input  wire logic [7:0]    req_blue,
   input  wire logic [7:0]    req_green,
   input  wire logic [7:0]    req_red,
   input  wire logic          fifo_full,
   output logic              fifo_wr,
   output pix_entry_type     fifo_data
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int WW = CW + 1;
   localparam int HW = RW + 1;
   localparam int AW = WW + HW;

   localparam int RESET_W = (DEFAULT_WIDTH  > MAX_WIDTH)  ? MAX_WIDTH  : DEFAULT_WIDTH;
   localparam int RESET_H = (DEFAULT_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : DEFAULT_HEIGHT;
   localparam logic [ADDR_WIDTH-1:0] RESET_BASE = ADDR_WIDTH'(RESET_W * RESET_H);

   logic [WW-1:0]         width_ff, width_in;
   logic [HW-1:0]         height_ff, height_in;
   logic [ADDR_WIDTH-1:0] base_ff, base_in;
   logic [CW-1:0]         col_ff, col_in;
   logic [RW-1:0]         row_ff, row_in;
   logic [ADDR_WIDTH-1:0] luma_ff, luma_in;
   logic [ADDR_WIDTH-1:0] chroma_ff, chroma_in;

   logic [WW-1:0]         clamp_w, new_w;
   logic [HW-1:0]         clamp_h, new_h;
   logic [AW-1:0]         area;
   logic                  cfg_hit;
   logic                  accept;
   logic                  has_chroma;
   logic [WW-1:0]         col_next;
   logic [HW-1:0]         row_next;

   logic [15:0]           y_sum;
   logic signed [16:0]    v_sum, u_sum;
   logic signed [16:0]    r_s, g_s, b_s;

   // zero reads as one, oversize saturates
   always_comb begin
      if (csr.data == '0) begin
         clamp_w = WW'(1);
         clamp_h = HW'(1);
      end else begin
         clamp_w = ({1'b0, csr.data} > 14'(MAX_WIDTH))  ? WW'(MAX_WIDTH)  : WW'(csr.data);
         clamp_h = ({1'b0, csr.data} > 14'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(csr.data);
      end
   end

   always_comb begin
      new_w   = width_ff;
      new_h   = height_ff;
      cfg_hit = 1'b0;
      if (csr.valid) begin
         case (csr.index)
            REG_FRAME_WIDTH: begin
               new_w   = clamp_w;
               cfg_hit = 1'b1;
            end
            REG_FRAME_HEIGHT: begin
               new_h   = clamp_h;
               cfg_hit = 1'b1;
            end
            default: begin
               cfg_hit = 1'b0;
            end
         endcase
      end
      area = AW'(new_w) * AW'(new_h);
   end

   // pixel conversion
   always_comb begin
      y_sum = 16'd66 * 16'(req_red) + 16'd129 * 16'(req_green)
            + 16'd25 * 16'(req_blue) + 16'd128;
      r_s   = $signed({9'b0, req_red});
      g_s   = $signed({9'b0, req_green});
      b_s   = $signed({9'b0, req_blue});
      v_sum = 17'sd112 * r_s - 17'sd94 * g_s - 17'sd18 * b_s + 17'sd128;
      u_sum = 17'sd112 * b_s - 17'sd38 * r_s - 17'sd74 * g_s + 17'sd128;
   end

   assign accept     = req_push && !fifo_full;
   assign has_chroma = !row_ff[0] && !col_ff[0];
   assign col_next   = WW'(col_ff) + 1'b1;
   assign row_next   = HW'(row_ff) + 1'b1;

   always_comb begin
      fifo_wr               = accept;
      fifo_data.luma_addr   = luma_ff;
      fifo_data.chroma_addr = chroma_ff;
      // floor shift then offset, kept to the low byte
      fifo_data.y_byte      = y_sum[15:8] + 8'd16;
      fifo_data.v_byte      = v_sum[15:8] + 8'd128;
      fifo_data.u_byte      = u_sum[15:8] + 8'd128;
      fifo_data.has_chroma  = has_chroma;
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      base_in   = base_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      luma_in   = luma_ff;
      chroma_in = chroma_ff;
      if (cfg_hit) begin
         width_in  = new_w;
         height_in = new_h;
         base_in   = ADDR_WIDTH'(area);
         col_in    = '0;
         row_in    = '0;
         luma_in   = '0;
         chroma_in = ADDR_WIDTH'(area);
      end else if (accept) begin
         luma_in   = luma_ff + 1'b1;
         chroma_in = has_chroma ? chroma_ff + ADDR_WIDTH'(2) : chroma_ff;
         col_in    = CW'(col_next);
         if (col_next >= width_ff) begin
            col_in = '0;
            row_in = RW'(row_next);
            if (row_next >= height_ff) begin
               row_in    = '0;
               luma_in   = '0;
               chroma_in = base_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WW'(RESET_W);
         height_ff <= HW'(RESET_H);
         base_ff   <= RESET_BASE;
         col_ff    <= '0;
         row_ff    <= '0;
         luma_ff   <= '0;
         chroma_ff <= RESET_BASE;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         base_ff   <= base_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         luma_ff   <= luma_in;
         chroma_ff <= chroma_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/rtnv_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtnv_back
// Walks the queue head through its Y and, with chroma, V and U writes, one
// word per cycle while the receiver pops, into a registered output word.
// ----------------------------------------------------------------------------
module rtnv_back
   import rtnv_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire pix_entry_type head,
   input  wire logic          fifo_empty,
   output logic              fifo_rd,
   input  wire logic          rsp_pop,
   output logic              rsp_empty,
   output logic [ADDR_WIDTH-1:0] rsp_write_address,
   output logic [7:0]        rsp_write_byte,
   output logic              rsp_is_chroma,
   output logic              rsp_last_of_pixel
);

   localparam logic [1:0] PHASE_Y = 2'd0;
   localparam logic [1:0] PHASE_V = 2'd1;
   localparam logic [1:0] PHASE_U = 2'd2;

   logic [1:0]            phase_ff, phase_in;
   logic                  valid_ff, valid_in;
   logic [ADDR_WIDTH-1:0] addr_ff, addr_in;
   logic [7:0]            byte_ff, byte_in;
   logic                  chroma_ff, chroma_in;
   logic                  last_ff, last_in;
   logic                  load;
   logic [1:0]            phase_next;

   assign load = !fifo_empty && (!valid_ff || rsp_pop);

   always_comb begin
      case (phase_ff)
         PHASE_V: begin
            addr_in    = head.chroma_addr;
            byte_in    = head.v_byte;
            chroma_in  = 1'b1;
            last_in    = 1'b0;
            phase_next = PHASE_U;
         end
         PHASE_U: begin
            addr_in    = head.chroma_addr + 1'b1;
            byte_in    = head.u_byte;
            chroma_in  = 1'b1;
            last_in    = 1'b1;
            phase_next = PHASE_Y;
         end
         default: begin
            addr_in    = head.luma_addr;
            byte_in    = head.y_byte;
            chroma_in  = 1'b0;
            last_in    = !head.has_chroma;
            phase_next = head.has_chroma ? PHASE_V : PHASE_Y;
         end
      endcase
   end

   always_comb begin
      fifo_rd  = load && last_in;
      phase_in = load ? phase_next : phase_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_Y;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         addr_ff   <= addr_in;
         byte_ff   <= byte_in;
         chroma_ff <= chroma_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_empty         = !valid_ff;
   assign rsp_write_address = addr_ff;
   assign rsp_write_byte    = byte_ff;
   assign rsp_is_chroma     = chroma_ff;
   assign rsp_last_of_pixel = last_ff;

endmodule
`default_nettype wire

// ===== sv/rgb_to_nv21_converter_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_to_nv21_converter_unit
// Streaming RGB to NV21 (BT.601) converter producing frame buffer byte writes.
//
// Pixels enter in raster order on the req_ side (push/full). Each pixel
// gives a luma write; pixels at an even row and even column also give a V
// and a U write into the interleaved chroma plane at width*height. Words
// leave on the rsp_ side (empty/pop), oldest first, last_of_pixel marking
// the final write of each pixel.
// Throughput: the output register issues one word per cycle while the queue
// has words and the receiver pops, a pixel giving one or three words there;
// the front takes a pixel every cycle while the four-entry queue has room.
// The csr_ port (always ready) sets frame_width (index 0) and frame_height
// (index 1) and restarts the frame; write only while idle.
// Reset returns to 640x480 at frame start with no words pending. A stalled
// receiver holds the current word; the queue then fills and raises full.
// ----------------------------------------------------------------------------
module rgb_to_nv21_converter_unit
   import rtnv_pkg::*;
#(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
)
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_push,
   output logic                           req_full,
   input  wire logic [7:0]                 req_blue,
   input  wire logic [7:0]                 req_green,
   input  wire logic [7:0]                 req_red,
   output logic                           rsp_empty,
   input  wire logic                       rsp_pop,
   output logic [ADDR_WIDTH-1:0]           rsp_write_address,
   output logic [7:0]                     rsp_write_byte,
   output logic                           rsp_is_chroma,
   output logic                           rsp_last_of_pixel,
   input  wire logic                       csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [DIM_WIDTH-1:0]       csr_data
);

   csr_write_type csr;
   pix_entry_type wr_data, head;
   logic          fifo_wr, fifo_rd, fifo_full, fifo_empty;

   assign csr_ready = 1'b1;
   assign csr.valid = csr_valid;
   assign csr.index = csr_index;
   assign csr.data  = csr_data;
   assign req_full  = fifo_full;

   rtnv_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr),
      .req_push  (req_push),
      .req_blue  (req_blue),
      .req_green (req_green),
      .req_red   (req_red),
      .fifo_full (fifo_full),
      .fifo_wr   (fifo_wr),
      .fifo_data (wr_data)
   );

   rtnv_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (fifo_wr),
      .wr_data (wr_data),
      .rd_en   (fifo_rd),
      .rd_data (head),
      .full    (fifo_full),
      .empty   (fifo_empty)
   );

   rtnv_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .fifo_empty        (fifo_empty),
      .fifo_rd           (fifo_rd),
      .rsp_pop           (rsp_pop),
      .rsp_empty         (rsp_empty),
      .rsp_write_address (rsp_write_address),
      .rsp_write_byte    (rsp_write_byte),
      .rsp_is_chroma     (rsp_is_chroma),
      .rsp_last_of_pixel (rsp_last_of_pixel)
   );

endmodule
`default_nettype wire

// ===== sv/rtnv_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtnv_checker
// Port-level checks of the converter's output word sequence.
// ----------------------------------------------------------------------------
module rtnv_checker
   import rtnv_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_full,
   input wire logic                  rsp_empty,
   input wire logic                  rsp_pop,
   input wire logic [ADDR_WIDTH-1:0] rsp_write_address,
   input wire logic                  rsp_is_chroma,
   input wire logic                  rsp_last_of_pixel
);

   logic rsp_take;
   assign rsp_take = rsp_pop && !rsp_empty;

   // nothing pending or blocked right after reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("words or full pending after reset");

   // a luma word that is not last is followed at once by the V word
   a_y_then_v: assert property (@(posedge clock) disable iff (reset)
      rsp_take && !rsp_is_chroma && !rsp_last_of_pixel
      |=> !rsp_empty && rsp_is_chroma && !rsp_last_of_pixel)
      else $error("chroma word missing after luma");

   // V is followed at once by U at the next address
   a_v_then_u: assert property (@(posedge clock) disable iff (reset)
      rsp_take && rsp_is_chroma && !rsp_last_of_pixel
      |=> !rsp_empty && rsp_is_chroma && rsp_last_of_pixel
          && rsp_write_address == $past(rsp_write_address) + 1'b1)
      else $error("U word missing or misplaced after V");

   // a waiting word is held until taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_write_address))
      else $error("waiting word changed");

endmodule

bind rgb_to_nv21_converter_unit rtnv_checker u_rtnv_checker (
   .clock             (clock),
   .reset             (reset),
   .req_full          (req_full),
   .rsp_empty         (rsp_empty),
   .rsp_pop           (rsp_pop),
   .rsp_write_address (rsp_write_address),
   .rsp_is_chroma     (rsp_is_chroma),
   .rsp_last_of_pixel (rsp_last_of_pixel)
);
`default_nettype wire

// ===== verif/rgb_to_nv21_write_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_nv21_write_checker
// Watches the pixel, write and register channels of the converter, predicts
// every NV21 byte write from the accepted pixels and compares each popped
// word, field by field, with the oldest predicted one.
// ----------------------------------------------------------------------------
module rgb_to_nv21_write_checker
   import rtnv_pkg::*;
#(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
)
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_push,
   input  wire logic                       req_full,
   input  wire logic [7:0]                 req_blue,
   input  wire logic [7:0]                 req_green,
   input  wire logic [7:0]                 req_red,
   input  wire logic                       rsp_empty,
   input  wire logic                       rsp_pop,
   input  wire logic [ADDR_WIDTH-1:0]      rsp_write_address,
   input  wire logic [7:0]                 rsp_write_byte,
   input  wire logic                       rsp_is_chroma,
   input  wire logic                       rsp_last_of_pixel,
   input  wire logic                       csr_valid,
   input  wire logic                       csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [DIM_WIDTH-1:0]       csr_data,
   output int                              fail_count,
   output int                              pending,
   output int                              writes_checked,
   output int                              chroma_writes
);

   typedef struct {
      logic [ADDR_WIDTH-1:0] address;
      logic [7:0]            data;
      logic                  chroma;
      logic                  last;
   } byte_write_type;

   byte_write_type expected_writes[$];

   logic [DIM_WIDTH-1:0]  frame_width;
   logic [DIM_WIDTH-1:0]  frame_height;
   logic [DIM_WIDTH-1:0]  column_count;
   logic [DIM_WIDTH-1:0]  row_count;
   logic [ADDR_WIDTH-1:0] luma_address;
   logic [ADDR_WIDTH-1:0] chroma_address;

   int errors         = 0;
   int checked        = 0;
   int chroma_checked = 0;

   // zero counts as one, anything past the maximum saturates
   function automatic int clamp_dim(logic [DIM_WIDTH-1:0] value, int max_value);
      if (value == 0) return 1;
      if (value > max_value) return max_value;
      return int'(value);
   endfunction

   // floor((sum + 128) / 256) + offset; >>> on a signed int rounds down
   function automatic logic [7:0] scale_to_byte(int sum, int offset);
      int scaled;
      scaled = ((sum + 128) >>> 8) + offset;
      return scaled[7:0];
   endfunction

   task automatic restart_frame();
      int area;
      area = clamp_dim(frame_width, MAX_WIDTH) * clamp_dim(frame_height, MAX_HEIGHT);
      column_count   = '0;
      row_count      = '0;
      luma_address   = '0;
      chroma_address = area[ADDR_WIDTH-1:0];
   endtask

   task automatic predict_pixel_writes(input logic [7:0] blue, input logic [7:0] green,
                                       input logic [7:0] red);
      int             b;
      int             g;
      int             r;
      logic           with_chroma;
      byte_write_type w;
      b = int'(blue);
      g = int'(green);
      r = int'(red);
      with_chroma = !row_count[0] && !column_count[0];

      w.address = luma_address;
      w.data    = scale_to_byte(66 * r + 129 * g + 25 * b, 16);
      w.chroma  = 1'b0;
      w.last    = !with_chroma;
      expected_writes.push_back(w);
      luma_address = luma_address + 1'b1;

      if (with_chroma) begin
         // V first, then U
         w.address = chroma_address;
         w.data    = scale_to_byte(112 * r - 94 * g - 18 * b, 128);
         w.chroma  = 1'b1;
         w.last    = 1'b0;
         expected_writes.push_back(w);
         chroma_address = chroma_address + 1'b1;
         w.address = chroma_address;
         w.data    = scale_to_byte(-38 * r - 74 * g + 112 * b, 128);
         w.last    = 1'b1;
         expected_writes.push_back(w);
         chroma_address = chroma_address + 1'b1;
      end

      column_count = column_count + 1'b1;
      if (column_count >= clamp_dim(frame_width, MAX_WIDTH)) begin
         column_count = '0;
         row_count    = row_count + 1'b1;
         if (row_count >= clamp_dim(frame_height, MAX_HEIGHT)) restart_frame();
      end
   endtask

   task automatic check_field(input string field, input logic [ADDR_WIDTH-1:0] expected_value,
                              input logic [ADDR_WIDTH-1:0] actual_value);
      if (actual_value !== expected_value) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h",
                  $time, field, expected_value, actual_value);
      end
   endtask

   always @(posedge clock) begin : watch
      byte_write_type oldest;
      if (reset) begin
         frame_width  = DIM_WIDTH'(DEFAULT_WIDTH);
         frame_height = DIM_WIDTH'(DEFAULT_HEIGHT);
         restart_frame();
         expected_writes.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            // unknown indexes leave the frame alone
            if (csr_index == REG_FRAME_WIDTH) begin
               frame_width = csr_data;
               restart_frame();
            end else if (csr_index == REG_FRAME_HEIGHT) begin
               frame_height = csr_data;
               restart_frame();
            end
         end
         // a pixel's first word shows only after the queue and output registers, so pop before push
         if (!rsp_empty && rsp_pop) begin
            if (expected_writes.size() == 0) begin
               errors++;
               $display("%0t: unexpected word, expected none, actual addr %0h byte %0h",
                        $time, rsp_write_address, rsp_write_byte);
            end else begin
               oldest = expected_writes.pop_front();
               check_field("write_address", oldest.address, rsp_write_address);
               check_field("write_byte", ADDR_WIDTH'(oldest.data),
                           ADDR_WIDTH'(rsp_write_byte));
               check_field("is_chroma", ADDR_WIDTH'(oldest.chroma),
                           ADDR_WIDTH'(rsp_is_chroma));
               check_field("last_of_pixel", ADDR_WIDTH'(oldest.last),
                           ADDR_WIDTH'(rsp_last_of_pixel));
               checked++;
               if (oldest.chroma) chroma_checked++;
            end
         end
         if (req_push && !req_full) predict_pixel_writes(req_blue, req_green, req_red);
      end
      pending        <= expected_writes.size();
      fail_count     <= errors;
      writes_checked <= checked;
      chroma_writes  <= chroma_checked;
   end

endmodule

// ===== verif/rgb_to_nv21_converter_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_nv21_converter_unit_test
// Drives pixels through the RGB to NV21 converter under a range of frame
// sizes (defaults, degenerate, saturated, small wrapping frames) with bursty
// input and a stalling receiver; the checker predicts and compares.
// ----------------------------------------------------------------------------
module rgb_to_nv21_converter_unit_test;
   import rtnv_pkg::*;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SPARE_3 = 2'd3;
   localparam int HOLD_CYCLES   = 64;
   localparam int HOLD_AFTER    = 80;
   localparam int IDLE_SETTLE   = 4;
   localparam int DRAIN_CYCLES  = 8;

   logic                       clock;
   logic                       reset;
   logic                       req_push;
   logic                       req_full;
   logic [7:0]                 req_blue;
   logic [7:0]                 req_green;
   logic [7:0]                 req_red;
   logic                       rsp_empty;
   logic                       rsp_pop;
   logic [ADDR_WIDTH-1:0]      rsp_write_address;
   logic [7:0]                 rsp_write_byte;
   logic                       rsp_is_chroma;
   logic                       rsp_last_of_pixel;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [DIM_WIDTH-1:0]       csr_data;

   int fail_count;
   int pending;
   int writes_checked;
   int chroma_writes;

   int  pixels_sent   = 0;
   int  frame_setups  = 0;
   logic hold_done    = 1'b0;

   // {blue, green, red}: corners of the cube, grays, and a pixel whose
   // chroma sum is negative but not a multiple of 256 (floor rounding)
   logic [23:0] directed_pixels [18] = '{
      24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00, 24'hFF0000, 24'hFFFF00,
      24'h00FFFF, 24'hFF00FF, 24'h000200, 24'h808080, 24'h010101, 24'hFEFEFE,
      24'h55AA55, 24'hAA55AA, 24'h0F3CF0, 24'hF0C30F, 24'h7F807F, 24'h000100
   };

   rgb_to_nv21_converter_unit uut (.*);

   rgb_to_nv21_write_checker u_checker (.*);

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic logic [7:0] pick_component();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_pixel(input logic [7:0] blue, input logic [7:0] green,
                             input logic [7:0] red);
      @(negedge clock);
      req_push  <= 1'b1;
      req_blue  <= blue;
      req_green <= green;
      req_red   <= red;
      do @(posedge clock); while (req_full);
      pixels_sent++;
   endtask

   task automatic pause_sender(input int cycles);
      @(negedge clock);
      req_push <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] index,
                                 input logic [DIM_WIDTH-1:0] data);
      while (pending != 0) @(posedge clock);
      repeat (IDLE_SETTLE) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic setup_frame(input logic [DIM_WIDTH-1:0] width,
                              input logic [DIM_WIDTH-1:0] height);
      write_register(REG_FRAME_WIDTH, width);
      write_register(REG_FRAME_HEIGHT, height);
      frame_setups++;
   endtask

   // bursts of random length with random gaps, sometimes none
   task automatic send_random_pixels(input int count);
      int left;
      int burst;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(1, 10);
         while (burst > 0 && left > 0) begin
            send_pixel(pick_component(), pick_component(), pick_component());
            burst--;
            left--;
         end
         if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 8));
      end
      pause_sender(1);
   endtask

   // receiver: its own stall pattern, plus one long hold so the queue fills
   initial begin : receiver
      int mode;
      int span;
      int held;
      rsp_pop = 1'b0;
      forever begin
         mode = $urandom_range(0, 2);
         span = $urandom_range(10, 60);
         repeat (span) begin
            @(negedge clock);
            if (!hold_done && pixels_sent >= HOLD_AFTER) begin
               hold_done = 1'b1;
               rsp_pop <= 1'b0;
               held = 0;
               while (held < HOLD_CYCLES) begin
                  @(negedge clock);
                  held++;
               end
            end
            case (mode)
               0: rsp_pop <= 1'b1;
               1: rsp_pop <= 1'($urandom_range(0, 1));
               default: rsp_pop <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   initial begin : stimulus
      reset     = 1'b1;
      req_push  = 1'b0;
      req_blue  = '0;
      req_green = '0;
      req_red   = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data  = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // default 640x480 frame, alternating luma-only and luma+chroma columns
      for (int i = 0; i < 14; i++) begin
         send_pixel(directed_pixels[i][23:16], directed_pixels[i][15:8],
                    directed_pixels[i][7:0]);
         if (i == 6) pause_sender(3);
      end
      pause_sender(1);
      // spare indexes are ignored: the frame must carry on where it was
      write_register(REG_SPARE_2, DIM_WIDTH'($urandom_range(0, 8191)));
      write_register(REG_SPARE_3, 13'h1FFF);
      for (int i = 14; i < 18; i++)
         send_pixel(directed_pixels[i][23:16], directed_pixels[i][15:8],
                    directed_pixels[i][7:0]);
      pause_sender(1);

      setup_frame(13'd0, 13'd0);         // degenerate 1x1
      send_random_pixels(12);
      setup_frame(13'h1FFF, 13'h1FFF);   // saturates to 4096x4096
      send_random_pixels(16);
      setup_frame(13'd4096, 13'd1);
      send_random_pixels(12);
      setup_frame(13'd1, 13'd4096);
      send_random_pixels(12);
      setup_frame(13'd3, 13'd3);
      send_random_pixels(30);
      setup_frame(13'd2, 13'd2);
      send_random_pixels(20);
      setup_frame(13'd5, 13'd2);
      send_random_pixels(24);
      repeat (3) begin
         setup_frame(DIM_WIDTH'($urandom_range(1, 6)), DIM_WIDTH'($urandom_range(1, 5)));
         send_random_pixels(9);
      end

      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Run covered %0d pixels over %0d frame setups and default size,",
               pixels_sent, frame_setups);
      $display("with %0d byte writes compared, %0d of them chroma.",
               writes_checked, chroma_writes);
      if (fail_count == 0 && pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
